>>> sv/sralu_pkg.sv
// Package: operation codes and fixed field widths of the stateful register ALU.
`default_nettype none

package sralu_pkg;

    localparam int ACTION_W = 3;
    localparam int BANK_W   = 2;
    localparam int KEY_W    = 12;
    localparam int DATA_W   = 16;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [DATA_W-1:0]   data_t;

    localparam action_t OP_CMP_ADD     = 3'd0;
    localparam action_t OP_MAX         = 3'd1;
    localparam action_t OP_SET         = 3'd2;
    localparam action_t OP_AND         = 3'd3;
    localparam action_t OP_OR          = 3'd4;
    localparam action_t OP_RANGE_COUNT = 3'd5;

    localparam data_t CMP_ADD_CEIL = 16'd65530;

endpackage

`default_nettype wire

>>> sv/stateful_register_alu.sv
// Stateful register ALU: read-modify-write over banks of 16-bit counters.
//
// One transaction in, one result out, one per cycle while m_ready is high. A
// transaction is read from memory and registered when accepted; modify, write-back
// and the output register follow when the stage advances, which m_ready low on a
// held result stalls. The counters sit in a single synchronous memory of NUM_BANKS *
// BANK_DEPTH words; a write-back to the entry that the following transaction reads
// is forwarded. After reset the block clears the memory one word a cycle, all
// NUM_BANKS * BANK_DEPTH words (16384 at the defaults), with s_ready low. Invalid
// actions, banks or keys return zero and leave the counters untouched.
`default_nettype none

module stateful_register_alu #(
    parameter int NUM_BANKS  = 4,
    parameter int BANK_DEPTH = 4096
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [sralu_pkg::ACTION_W-1:0]     s_action,
    input  wire  [sralu_pkg::BANK_W-1:0]       s_bank,
    input  wire  [sralu_pkg::KEY_W-1:0]        s_key,
    input  wire  [sralu_pkg::DATA_W-1:0]       s_val,
    input  wire  [sralu_pkg::DATA_W-1:0]       s_param,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [sralu_pkg::DATA_W-1:0]       m_result
);

    localparam int DEPTH  = NUM_BANKS * BANK_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    sralu_pkg::data_t mem [DEPTH];
    sralu_pkg::data_t rdata_reg;

    logic                    clearing_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;

    logic                    st1_valid_reg;
    logic                    st1_ok_reg;
    sralu_pkg::action_t      st1_op_reg;
    logic [ADDR_W-1:0]       st1_addr_reg;
    sralu_pkg::data_t        st1_val_reg;
    sralu_pkg::data_t        st1_param_reg;
    logic                    fwd_hit_reg;
    sralu_pkg::data_t        fwd_data_reg;

    logic                    m_valid_reg;
    sralu_pkg::data_t        m_result_reg;

    logic                    advance;
    logic                    accept;
    logic                    in_ok;
    logic [ADDR_W-1:0]       in_addr;
    sralu_pkg::data_t        cur;
    sralu_pkg::data_t        new_val;
    sralu_pkg::data_t        res;
    logic                    wr_op;
    logic                    wr_en;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    sralu_pkg::data_t        mem_wdata;

    assign advance = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing_reg && (!st1_valid_reg || advance);
    assign accept  = s_valid && s_ready;

    assign in_ok = (32'(s_bank) < NUM_BANKS) && (32'(s_key) < BANK_DEPTH)
                   && (s_action <= sralu_pkg::OP_RANGE_COUNT);
    assign in_addr = ADDR_W'(s_bank) * ADDR_W'(BANK_DEPTH) + ADDR_W'(s_key);

    assign cur = fwd_hit_reg ? fwd_data_reg : rdata_reg;

    always_comb begin
        new_val = cur;
        res     = '0;
        wr_op   = 1'b0;
        case (st1_op_reg)
            sralu_pkg::OP_CMP_ADD: begin
                if (cur < st1_param_reg) begin
                    new_val = (cur > sralu_pkg::CMP_ADD_CEIL) ? cur : cur + st1_val_reg;
                    res     = new_val;
                    wr_op   = 1'b1;
                end else begin
                    res = st1_param_reg;
                end
            end
            sralu_pkg::OP_MAX: begin
                if (cur < st1_val_reg) begin
                    new_val = st1_val_reg;
                    res     = cur;
                    wr_op   = 1'b1;
                end else begin
                    res = st1_val_reg;
                end
            end
            sralu_pkg::OP_SET: begin
                new_val = st1_val_reg;
                res     = (st1_param_reg == '0) ? st1_val_reg : cur;
                wr_op   = 1'b1;
            end
            sralu_pkg::OP_AND: begin
                res = cur & st1_val_reg;
            end
            sralu_pkg::OP_OR: begin
                new_val = cur | st1_val_reg;
                res     = cur;
                wr_op   = 1'b1;
            end
            sralu_pkg::OP_RANGE_COUNT: begin
                new_val = (st1_val_reg < st1_param_reg) ? cur + 16'd1 : st1_val_reg;
                res     = new_val;
                wr_op   = 1'b1;
            end
            default: begin
                res = '0;
            end
        endcase
        if (!st1_ok_reg) begin
            res   = '0;
            wr_op = 1'b0;
        end
    end

    assign wr_en     = advance && wr_op;
    assign mem_we    = clearing_reg || wr_en;
    assign mem_waddr = clearing_reg ? clr_addr_reg : st1_addr_reg;
    assign mem_wdata = clearing_reg ? '0 : new_val;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rdata_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept) begin
                st1_valid_reg <= 1'b1;
            end else if (advance) begin
                st1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_ok_reg    <= in_ok;
            st1_op_reg    <= s_action;
            st1_addr_reg  <= in_addr;
            st1_val_reg   <= s_val;
            st1_param_reg <= s_param;
            fwd_hit_reg   <= wr_en && (in_addr == st1_addr_reg);
            fwd_data_reg  <= new_val;
        end
        if (advance) begin
            m_result_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

`default_nettype wire
